// ===== rtl/crrc_pkg.sv =====
// shared constants, codes and types of the compute region residency checker
package crrc_pkg;

    localparam int SLOTS        = 64;
    localparam int MAX_OPERANDS = 3;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int QUBIT_W      = 16;
    localparam int ACT_W        = 7;
    localparam int CMP_W        = (SLOT_W > ACT_W) ? SLOT_W : ACT_W;
    localparam int OP_FIELDS    = 3;
    localparam int OP_LIMIT     = (MAX_OPERANDS < OP_FIELDS) ? MAX_OPERANDS : OP_FIELDS;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        REQ_MOVE = 2'd0,
        REQ_SOFT = 2'd1,
        REQ_GATE = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ERR_NONE            = 2'd0,
        ERR_IN_RESIDENT     = 2'd1,
        ERR_OUT_ABSENT      = 2'd2,
        ERR_OPERAND_MISSING = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [1:0]         operand_count;
        logic [QUBIT_W-1:0] qubit_a;
    } req_info_t;

    typedef struct packed {
        logic hit_a;
        logic hit_b;
        logic hit_c;
    } lane_hit_t;

    typedef struct packed {
        logic [SLOTS-1:0] hit_a;
        logic [SLOTS-1:0] hit_b;
        logic [SLOTS-1:0] hit_c;
    } match_vec_t;

    typedef struct packed {
        logic               en;
        logic [SLOTS-1:0]   sel;
        logic [QUBIT_W-1:0] data;
    } slot_wr_t;

endpackage

// ===== rtl/crrc_lane.sv =====
// one compute slot: its table entry and the operand comparators
module crrc_lane
    import crrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [SLOT_W-1:0]  lane_idx,
    input  logic [ACT_W-1:0]   active_slots,
    input  logic               capture,
    input  logic [QUBIT_W-1:0] qubit_a,
    input  logic [QUBIT_W-1:0] qubit_b,
    input  logic [QUBIT_W-1:0] qubit_c,
    input  logic               wr_en,
    input  logic [QUBIT_W-1:0] wr_data,
    output lane_hit_t          hit
);

    logic [QUBIT_W-1:0] entry_reg;
    logic [QUBIT_W-1:0] entry_next;
    lane_hit_t          hit_reg;
    lane_hit_t          hit_next;
    logic               active;

    assign active = CMP_W'(lane_idx) < CMP_W'(active_slots);

    always_comb begin
        entry_next     = wr_en ? wr_data : entry_reg;
        hit_next.hit_a = active && (entry_reg == qubit_a);
        hit_next.hit_b = active && (entry_reg == qubit_b);
        hit_next.hit_c = active && (entry_reg == qubit_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= QUBIT_W'(lane_idx);
        end else begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== rtl/crrc_merge.sv =====
// merges the lane hits into a verdict, picks the replaced slot, holds the result
module crrc_merge
    import crrc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   match_vld,
    input  match_vec_t             match,
    input  req_info_t              info,
    input  logic                   check_enable,
    output logic                   take,
    output slot_wr_t               wr,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata  // item_ok, error_code
);

    logic      out_vld_reg;
    logic      out_vld_next;
    logic      out_ok_reg;
    logic      out_ok_next;
    err_code_t out_code_reg;
    err_code_t out_code_next;
    logic      failed_reg;
    logic      failed_next;
    err_code_t first_code_reg;
    err_code_t first_code_next;

    err_code_t code;
    logic      any_a;
    logic      any_b;
    logic      any_c;
    logic      missing;
    logic [1:0] op_n;
    logic [SLOTS-1:0] low_b;

    assign any_a = |match.hit_a;
    assign any_b = |match.hit_b;
    assign any_c = |match.hit_c;
    assign low_b = match.hit_b & (~match.hit_b + SLOTS'(1));

    always_comb begin
        op_n    = (info.operand_count > 2'(OP_LIMIT)) ? 2'(OP_LIMIT) : info.operand_count;
        missing = ((op_n >= 2'd1) && !any_a) ||
                  ((op_n >= 2'd2) && !any_b) ||
                  ((op_n >= 2'd3) && !any_c);
    end

    always_comb begin
        code    = ERR_NONE;
        wr.en   = 1'b0;
        wr.sel  = low_b;
        wr.data = info.qubit_a;
        take    = match_vld && (!out_vld_reg || m_tready);
        if (check_enable) begin
            unique case (info.req_type)
                REQ_MOVE: begin
                    if (any_a) begin
                        code = ERR_IN_RESIDENT;
                    end else if (!any_b) begin
                        code = ERR_OUT_ABSENT;
                    end else begin
                        wr.en = take && !failed_reg;
                    end
                end
                REQ_SOFT: begin
                    code = ERR_NONE;
                end
                default: begin
                    code = missing ? ERR_OPERAND_MISSING : ERR_NONE;
                end
            endcase
        end

        out_vld_next    = take || (out_vld_reg && !m_tready);
        out_ok_next     = out_ok_reg;
        out_code_next   = out_code_reg;
        failed_next     = failed_reg;
        first_code_next = first_code_reg;
        if (take) begin
            if (failed_reg) begin
                out_ok_next   = 1'b0;
                out_code_next = first_code_reg;
            end else begin
                out_ok_next   = (code == ERR_NONE);
                out_code_next = code;
                if (code != ERR_NONE) begin
                    failed_next     = 1'b1;
                    first_code_next = code;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg    <= 1'b0;
            failed_reg     <= 1'b0;
            first_code_reg <= ERR_NONE;
        end else begin
            out_vld_reg    <= out_vld_next;
            failed_reg     <= failed_next;
            first_code_reg <= first_code_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ok_reg   <= out_ok_next;
        out_code_reg <= out_code_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_TDATA_W-3){1'b0}}, out_code_reg, out_ok_reg};

endmodule

// ===== rtl/compute_region_residency_checker.sv =====
// top level of the compute region residency checker
// When an instruction is accepted every slot lane compares its table entry against the three
// operands and registers its hits; the merge stage then reduces the hits, decides the verdict
// and writes the replaced slot for a move once the output register can take the result. A new
// instruction is accepted once the previous one has been merged, so the checker cannot take a
// new instruction before it is through with the last; one finished result may wait in the output
// register while the next instruction is compared. After reset slot i holds qubit id i.
module compute_region_residency_checker
    import crrc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // req_type, operand_count, qubit_a, qubit_b, qubit_c
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // item_ok, error_code
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ACT_W-1:0]       cfg_wr_data
);

    logic [ACT_W-1:0]   active_slots_reg;
    logic [ACT_W-1:0]   active_slots_next;
    logic               check_enable_reg;
    logic               check_enable_next;
    logic               match_vld_reg;
    logic               match_vld_next;
    req_info_t          info_reg;
    req_info_t          info_next;

    logic               in_fire;
    logic               take;
    slot_wr_t           wr;
    match_vec_t         match;
    logic [QUBIT_W-1:0] qubit_a;
    logic [QUBIT_W-1:0] qubit_b;
    logic [QUBIT_W-1:0] qubit_c;

    assign qubit_a  = s_tdata[19:4];
    assign qubit_b  = s_tdata[35:20];
    assign qubit_c  = s_tdata[51:36];
    assign s_tready = !match_vld_reg;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        active_slots_next = active_slots_reg;
        check_enable_next = check_enable_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ACTIVE_SLOTS: active_slots_next = cfg_wr_data;
                CFG_CHECK_ENABLE: check_enable_next = cfg_wr_data[0];
            endcase
        end

        match_vld_next = match_vld_reg;
        if (in_fire) begin
            match_vld_next = 1'b1;
        end else if (take) begin
            match_vld_next = 1'b0;
        end

        info_next.req_type      = s_tdata[1:0];
        info_next.operand_count = s_tdata[3:2];
        info_next.qubit_a       = qubit_a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_slots_reg <= 7'd64;
            check_enable_reg <= 1'b1;
            match_vld_reg    <= 1'b0;
        end else begin
            active_slots_reg <= active_slots_next;
            check_enable_reg <= check_enable_next;
            match_vld_reg    <= match_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            info_reg <= info_next;
        end
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_lane
        lane_hit_t hit;

        crrc_lane u_lane (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .lane_idx     (SLOT_W'(i)),
            .active_slots (active_slots_reg),
            .capture      (in_fire),
            .qubit_a      (qubit_a),
            .qubit_b      (qubit_b),
            .qubit_c      (qubit_c),
            .wr_en        (wr.en && wr.sel[i]),
            .wr_data      (wr.data),
            .hit          (hit)
        );

        assign match.hit_a[i] = hit.hit_a;
        assign match.hit_b[i] = hit.hit_b;
        assign match.hit_c[i] = hit.hit_c;
    end

    crrc_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .match_vld    (match_vld_reg),
        .match        (match),
        .info         (info_reg),
        .check_enable (check_enable_reg),
        .take         (take),
        .wr           (wr),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ===== rtl/crrc_checker.sv =====
// port level checks of the residency checker and their binding to the top level
module crrc_checker
    import crrc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata  // item_ok, error_code
);

    logic      seen_fail_reg;
    logic      seen_fail_next;
    logic [1:0] fail_code_reg;
    logic [1:0] fail_code_next;
    logic      out_fire;

    assign out_fire = m_tvalid && m_tready;

    always_comb begin
        seen_fail_next = seen_fail_reg;
        fail_code_next = fail_code_reg;
        if (out_fire && !seen_fail_reg && !m_tdata[0]) begin
            seen_fail_next = 1'b1;
            fail_code_next = m_tdata[2:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_fail_reg <= 1'b0;
            fail_code_reg <= 2'd0;
        end else begin
            seen_fail_reg <= seen_fail_next;
            fail_code_reg <= fail_code_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a passing transaction carries no error code
    a_ok_no_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == ERR_NONE)
        else $error("passing result with error code");

    // failure is sticky and repeats its first code
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && seen_fail_reg |-> !m_tdata[0] && m_tdata[2:1] == fail_code_reg)
        else $error("failure not sticky");

    // one instruction in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted back to back");

endmodule

bind compute_region_residency_checker crrc_checker u_crrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/testbench.sv =====
// testbench for the compute region residency checker: directed cases and random instruction streams, scoreboard check
`timescale 1ns / 100ps

module testbench;
    import crrc_pkg::*;

    localparam logic [1:0] REQ_UNDEF = 2'd3;

    typedef struct packed {
        logic [QUBIT_W-1:0] qubit_c;
        logic [QUBIT_W-1:0] qubit_b;
        logic [QUBIT_W-1:0] qubit_a;
        logic [1:0]         operand_count;
        logic [1:0]         req_type;
    } instruction_t;

    typedef struct packed {
        logic      item_ok;
        err_code_t code;
    } verdict_t;

    class residency_scoreboard;
        logic [QUBIT_W-1:0] slot_table [SLOTS];
        bit                 failed;
        err_code_t          first_code;
        int unsigned        active_slots;
        bit                 check_enable;
        verdict_t           verdict_q [$];
        int                 errors;

        function new();
            for (int i = 0; i < SLOTS; i++) slot_table[i] = QUBIT_W'(i);
            failed       = 1'b0;
            first_code   = ERR_NONE;
            active_slots = SLOTS;
            check_enable = 1'b1;
            errors       = 0;
        endfunction

        function int active_count();
            return (active_slots > SLOTS) ? SLOTS : active_slots;
        endfunction

        function int find_slot(logic [QUBIT_W-1:0] id);
            for (int i = 0; i < active_count(); i++)
                if (slot_table[i] == id) return i;
            return -1;
        endfunction

        // verdict of an instruction on the current table, ignoring the sticky failure
        function err_code_t evaluate(instruction_t r);
            logic [QUBIT_W-1:0] ops [OP_FIELDS];
            int                 n;
            if (!check_enable) return ERR_NONE;
            if (r.req_type == REQ_MOVE) begin
                if (find_slot(r.qubit_a) >= 0) return ERR_IN_RESIDENT;
                if (find_slot(r.qubit_b) < 0) return ERR_OUT_ABSENT;
                return ERR_NONE;
            end
            if (r.req_type == REQ_SOFT) return ERR_NONE;
            ops[0] = r.qubit_a;
            ops[1] = r.qubit_b;
            ops[2] = r.qubit_c;
            n = (r.operand_count > OP_LIMIT) ? OP_LIMIT : r.operand_count;
            for (int i = 0; i < n; i++)
                if (find_slot(ops[i]) < 0) return ERR_OPERAND_MISSING;
            return ERR_NONE;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ACT_W-1:0] value);
            if (idx == CFG_ACTIVE_SLOTS) active_slots = value;
            else check_enable = value[0];
        endfunction

        function void add_verdict(logic ok, err_code_t c);
            verdict_t v;
            v.item_ok = ok;
            v.code    = c;
            verdict_q.insert(verdict_q.size(), v);
        endfunction

        function void note_request(instruction_t r);
            err_code_t code;
            if (failed) begin
                add_verdict(1'b0, first_code);
                return;
            end
            code = evaluate(r);
            if (code != ERR_NONE) begin
                failed     = 1'b1;
                first_code = code;
                add_verdict(1'b0, code);
            end else begin
                if (check_enable && r.req_type == REQ_MOVE)
                    slot_table[find_slot(r.qubit_b)] = r.qubit_a;
                add_verdict(1'b1, ERR_NONE);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            verdict_t want;
            if (verdict_q.size() == 0) begin
                errors++;
                $error("result transaction with nothing expected: %h", data);
                return;
            end
            want = verdict_q[0];
            verdict_q.delete(0);
            if (data[0] !== want.item_ok) begin
                errors++;
                $error("item_ok: expected %0d, actual %0d", want.item_ok, data[0]);
            end
            if (data[2:1] !== want.code) begin
                errors++;
                $error("error_code: expected %0d, actual %0d", want.code, data[2:1]);
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [ACT_W-1:0]       cfg_wr_data;

    residency_scoreboard board;
    bit                  holdoff_req;
    int                  burst_left;

    always #2 aclk = ~aclk;

    compute_region_residency_checker i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic logic [QUBIT_W-1:0] absent_id();
        logic [QUBIT_W-1:0] id;
        id = QUBIT_W'($urandom);
        while (board.find_slot(id) >= 0) id = QUBIT_W'($urandom);
        return id;
    endfunction

    function automatic logic [QUBIT_W-1:0] resident_id();
        return board.slot_table[$urandom_range(0, board.active_count() - 1)];
    endfunction

    // legal instructions keep the checker out of the sticky failure state
    function automatic instruction_t random_instruction(bit legal);
        instruction_t r;
        int           n;
        int           pick;
        r.qubit_a       = QUBIT_W'($urandom);
        r.qubit_b       = QUBIT_W'($urandom);
        r.qubit_c       = QUBIT_W'($urandom);
        r.operand_count = 2'($urandom_range(0, 3));
        r.req_type      = 2'($urandom_range(0, 3));
        if (!legal) return r;
        n    = board.active_count();
        pick = $urandom_range(0, 99);
        if (pick < 35) r.req_type = REQ_MOVE;
        else if (pick < 50) r.req_type = REQ_SOFT;
        else if (pick < 90) r.req_type = REQ_GATE;
        else r.req_type = REQ_UNDEF;
        if (n == 0) begin
            if (r.req_type == REQ_MOVE) r.req_type = REQ_SOFT;
            r.operand_count = 2'd0;
        end else if (r.req_type == REQ_MOVE) begin
            if (n < SLOTS && $urandom_range(0, 2) == 0)
                r.qubit_a = board.slot_table[$urandom_range(n, SLOTS - 1)];
            else
                r.qubit_a = absent_id();
            r.qubit_b = resident_id();
        end else if (r.req_type != REQ_SOFT) begin
            if (r.operand_count > 0) r.qubit_a = resident_id();
            if (r.operand_count > 1) r.qubit_b = resident_id();
            if (r.operand_count > 2) r.qubit_c = resident_id();
        end
        if (board.evaluate(r) != ERR_NONE) r.req_type = REQ_SOFT;
        return r;
    endfunction

    task automatic send_request(instruction_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - $bits(instruction_t)){1'b0}}, r};
        do @(posedge aclk); while (!s_tready);
        board.note_request(r);
    endtask

    task automatic send_fields(logic [1:0] req, logic [1:0] cnt, logic [QUBIT_W-1:0] qa,
                               logic [QUBIT_W-1:0] qb, logic [QUBIT_W-1:0] qc);
        send_request('{qc, qb, qa, cnt, req});
    endtask

    task automatic idle_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ACT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        board.write_reg(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(int count, bit legal, int holdoff_at, int drain_at);
        for (int i = 0; i < count; i++) begin
            if (i == holdoff_at) holdoff_req = 1'b1;
            if (i == drain_at) wait_drained();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
            end
            burst_left--;
            send_request(random_instruction(legal));
        end
    endtask

    initial begin
        int unsigned  active;
        bit           enable;
        instruction_t bad;
        board       = new();
        holdoff_req = 1'b0;
        burst_left  = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_ACTIVE_SLOTS;
        cfg_wr_data = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_fields(REQ_GATE, 2'd3, 16'd0, 16'd63, 16'd1);
        send_fields(REQ_GATE, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(REQ_SOFT, 2'd3, 16'hFFFF, 16'hFFFE, 16'h8000);
        send_fields(REQ_UNDEF, 2'd2, 16'd62, 16'd61, 16'hFFFF);
        send_fields(REQ_MOVE, 2'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        send_fields(REQ_GATE, 2'd1, 16'hFFFF, 16'h1234, 16'hFFFF);
        send_fields(REQ_MOVE, 2'd3, 16'd0, 16'hFFFF, 16'd0);
        wait_drained();
        write_reg(CFG_ACTIVE_SLOTS, 7'd2);
        send_fields(REQ_MOVE, 2'd1, 16'd5, 16'd0, 16'd0);
        send_fields(REQ_GATE, 2'd1, 16'd1, 16'd40, 16'd50);
        wait_drained();
        write_reg(CFG_ACTIVE_SLOTS, 7'd127);
        send_fields(REQ_MOVE, 2'd0, 16'd100, 16'd5, 16'd0);
        send_fields(REQ_GATE, 2'd3, 16'd5, 16'd100, 16'd63);
        wait_drained();
        write_reg(CFG_CHECK_ENABLE, 7'd0);
        send_fields(REQ_MOVE, 2'd0, 16'd1, 16'd1, 16'd0);
        send_fields(REQ_GATE, 2'd3, 16'hFFFE, 16'hFFFD, 16'hFFFC);
        send_fields(REQ_UNDEF, 2'd3, 16'hAAAA, 16'h5555, 16'hFFFF);
        wait_drained();
        write_reg(CFG_ACTIVE_SLOTS, 7'd0);
        write_reg(CFG_CHECK_ENABLE, 7'd1);
        send_fields(REQ_SOFT, 2'd2, 16'd0, 16'd1, 16'd2);
        send_fields(REQ_GATE, 2'd0, 16'd0, 16'd1, 16'd2);
        send_fields(REQ_UNDEF, 2'd0, 16'd3, 16'd4, 16'd5);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: active = 64;
                1: active = 1;
                2: active = 127;
                3: active = 0;
                4: active = $urandom_range(3, 63);
                5: active = 2;
                6: active = 64;
                default: active = $urandom_range(1, 64);
            endcase
            enable = !(p == 3 || p == 6);
            wait_drained();
            write_reg(CFG_ACTIVE_SLOTS, ACT_W'(active));
            write_reg(CFG_CHECK_ENABLE, ACT_W'(enable));
            run_phase(200, enable, (p == 0) ? 60 : -1, (p == 1) ? 100 : -1);
        end

        wait_drained();
        write_reg(CFG_ACTIVE_SLOTS, 7'd64);
        write_reg(CFG_CHECK_ENABLE, 7'd1);
        bad.req_type      = REQ_MOVE;
        bad.operand_count = 2'($urandom_range(0, 3));
        bad.qubit_c       = QUBIT_W'($urandom);
        case ($urandom_range(1, 3))
            1: begin
                bad.qubit_a = resident_id();
                bad.qubit_b = bad.qubit_a;
            end
            2: begin
                bad.qubit_a = absent_id();
                bad.qubit_b = absent_id();
            end
            default: begin
                bad.req_type      = REQ_GATE;
                bad.operand_count = 2'd3;
                bad.qubit_a       = resident_id();
                bad.qubit_b       = resident_id();
                bad.qubit_c       = absent_id();
            end
        endcase
        send_request(bad);
        run_phase(60, 1'b0, -1, -1);
        wait_drained();
        write_reg(CFG_CHECK_ENABLE, 7'd0);
        run_phase(60, 1'b0, -1, -1);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        int stall_pct;
        int hold_left;
        int cycle;
        stall_pct = 0;
        hold_left = 0;
        cycle     = 0;
        m_tready  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            cycle++;
            if (cycle % 48 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            if (holdoff_req) begin
                hold_left   = 300;
                holdoff_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== compute_region_residency_checker.f =====
rtl/crrc_pkg.sv
rtl/crrc_lane.sv
rtl/crrc_merge.sv
rtl/compute_region_residency_checker.sv
rtl/crrc_checker.sv
bench/testbench.sv
